/* src/scrd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scrd_pkg: shared types and constants of the response deframer
// Word layouts of both channels, status and request codes, framing constants.
// ----------------------------------------------------------------------------
package scrd_pkg;

    // input word
    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_word;

    // output word
    typedef struct packed {
        logic        kind;
        logic [7:0]  param_byte;
        logic [15:0] param_index;
        logic [2:0]  status;
        logic [7:0]  confirm_code;
        logic [15:0] param_count;
        logic        frame_done;
    } t_out_word;

    // request codes
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // output kinds
    localparam logic KIND_PARAM  = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    // frame status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_BAD_ID     = 3'd2;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
    localparam logic [2:0] ST_BAD_SUM    = 3'd4;

    // configuration register indexes
    localparam logic CFG_IDX_PACKET_ID  = 1'b0;
    localparam logic CFG_IDX_MAX_LENGTH = 1'b1;

    // configuration reset values
    localparam logic [7:0]  RESET_PACKET_ID  = 8'h07;
    localparam logic [15:0] RESET_MAX_LENGTH = 16'd32;

    // header layout
    localparam logic [7:0]  HDR_BYTE0   = 8'hEF;
    localparam logic [7:0]  HDR_BYTE1   = 8'h01;
    localparam logic [15:0] POS_SYNC0   = 16'd0;
    localparam logic [15:0] POS_SYNC1   = 16'd1;
    localparam logic [15:0] POS_ID      = 16'd6;
    localparam logic [15:0] POS_LEN_HI  = 16'd7;
    localparam logic [15:0] POS_HDR_END = 16'd8;
    localparam logic [15:0] MIN_LENGTH  = 16'd3;

endpackage : scrd_pkg

`default_nettype wire

/* src/sum_checked_response_deframer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sum_checked_response_deframer: response frame parser with 16-bit sum check
// Usage:
//   Input channel (i_in_valid / i_in_data / o_in_stall): one word per received
//   byte, or a restart word that drops any partial frame. A word is taken on a
//   clock edge with valid high and stall low.
//   Output channel (o_out_valid / o_out_data / i_out_stall): parameter bytes as
//   they arrive, then one frame result word (frame_done set) per frame or per
//   rejected header. Parameters are only good if that result says ok.
//   Config port (i_cfg_we / i_cfg_idx / i_cfg_data): index 0 packet id, index 1
//   max length. Write only while idle.
// A result is registered: it enters the output register as its word is taken.
// Throughput: one word per cycle unless a held result stalls; parser state
//   updates in one pass; the output register refills in the cycle it drains.
// Reset (synchronous, i_rst_n low): framing state cleared, output empty,
//   packet id back to 0x07 and max length back to 32.
// Stall: a held result word with i_out_stall high raises o_in_stall; words
//   that give no result still need the output free before being taken.
// ----------------------------------------------------------------------------
module sum_checked_response_deframer
    import scrd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    input  wire t_in_word    i_in_data,
    output logic             o_in_stall,
    // output channel
    output logic             o_out_valid,
    output t_out_word        o_out_data,
    input  wire logic        i_out_stall,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    logic [7:0]  r_pkt_id;
    logic [15:0] r_max_length;
    logic        w_fire;
    logic        w_busy;
    logic        w_res_valid;
    t_out_word   w_res;

    // word taken whenever the result register can take what it produces
    assign o_in_stall = w_busy;
    assign w_fire     = i_in_valid && !w_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_id     <= RESET_PACKET_ID;
            r_max_length <= RESET_MAX_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_PACKET_ID: begin
                    r_pkt_id <= i_cfg_data[7:0];
                end
                CFG_IDX_MAX_LENGTH: begin
                    r_max_length <= i_cfg_data;
                end
            endcase
        end
    end

    scrd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_word       (i_in_data),
        .i_packet_id  (r_pkt_id),
        .i_max_length (r_max_length),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    scrd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_stall     (i_out_stall),
        .o_busy      (w_busy),
        .o_valid     (o_out_valid),
        .o_word      (o_out_data)
    );

endmodule : sum_checked_response_deframer

`default_nettype wire

/* src/scrd_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scrd_parser: frame state and per-byte decode
// Holds the framing state and works out, for each accepted word, the next
// state and the optional result word in one pass.
// ----------------------------------------------------------------------------
module scrd_parser
    import scrd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire t_in_word    i_word,
    input  wire logic [7:0]  i_packet_id,
    input  wire logic [15:0] i_max_length,
    output logic             o_res_valid,
    output t_out_word        o_res
);

    logic        r_in_body,   n_in_body;
    logic [15:0] r_byte_pos,  n_byte_pos;
    logic [15:0] r_frame_len, n_frame_len;
    logic [15:0] r_sum,       n_sum;
    logic [7:0]  r_chk_high,  n_chk_high;
    logic [7:0]  r_confirm,   n_confirm;
    logic        r_hdr_fault, n_hdr_fault;
    logic        r_id_fault,  n_id_fault;

    logic [7:0]  w_b;
    logic [15:0] w_len_full;
    logic [15:0] w_sum_add;
    logic        w_is_last;
    logic        w_is_chk_high;

    assign w_b           = i_word.rx_byte;
    assign w_len_full    = r_frame_len | {8'd0, w_b};
    assign w_sum_add     = r_sum + {8'd0, w_b};
    assign w_is_last     = (r_byte_pos == (r_frame_len - 16'd1));
    assign w_is_chk_high = (r_byte_pos == (r_frame_len - 16'd2));

    always_comb begin
        n_in_body   = r_in_body;
        n_byte_pos  = r_byte_pos;
        n_frame_len = r_frame_len;
        n_sum       = r_sum;
        n_chk_high  = r_chk_high;
        n_confirm   = r_confirm;
        n_hdr_fault = r_hdr_fault;
        n_id_fault  = r_id_fault;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_word.req_type == REQ_RESTART) begin
            n_in_body   = 1'b0;
            n_byte_pos  = '0;
            n_frame_len = '0;
            n_sum       = '0;
            n_chk_high  = '0;
            n_confirm   = '0;
            n_hdr_fault = 1'b0;
            n_id_fault  = 1'b0;
        end else if (!r_in_body) begin
            if (r_byte_pos == POS_SYNC0 && w_b != HDR_BYTE0) begin
                n_hdr_fault = 1'b1;
            end
            if (r_byte_pos == POS_SYNC1 && w_b != HDR_BYTE1) begin
                n_hdr_fault = 1'b1;
            end
            if (r_byte_pos == POS_ID) begin
                if (w_b != i_packet_id) begin
                    n_id_fault = 1'b1;
                end
                n_sum = {8'd0, w_b};
            end
            if (r_byte_pos == POS_LEN_HI) begin
                n_frame_len = {w_b, 8'd0};
                n_sum       = w_sum_add;
            end
            if (r_byte_pos == POS_HDR_END) begin
                // header complete: judge it, faults in priority order
                n_frame_len = w_len_full;
                n_sum       = w_sum_add;
                n_byte_pos  = '0;
                o_res.kind       = KIND_RESULT;
                o_res.frame_done = 1'b1;
                if (r_hdr_fault) begin
                    o_res.status = ST_BAD_HEADER;
                    o_res_valid  = 1'b1;
                end else if (r_id_fault) begin
                    o_res.status = ST_BAD_ID;
                    o_res_valid  = 1'b1;
                end else if (w_len_full < MIN_LENGTH || w_len_full > i_max_length) begin
                    o_res.status = ST_BAD_LENGTH;
                    o_res_valid  = 1'b1;
                end
                if (o_res_valid) begin
                    n_in_body   = 1'b0;
                    n_frame_len = '0;
                    n_sum       = '0;
                    n_chk_high  = '0;
                    n_confirm   = '0;
                    n_hdr_fault = 1'b0;
                    n_id_fault  = 1'b0;
                end else begin
                    n_in_body = 1'b1;
                end
            end else begin
                n_byte_pos = r_byte_pos + 16'd1;
            end
        end else begin
            if (w_is_last) begin
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_RESULT;
                o_res.frame_done = 1'b1;
                if ({r_chk_high, w_b} == r_sum) begin
                    o_res.status       = ST_OK;
                    o_res.confirm_code = r_confirm;
                    o_res.param_count  = r_frame_len - MIN_LENGTH;
                end else begin
                    o_res.status = ST_BAD_SUM;
                end
                n_in_body   = 1'b0;
                n_byte_pos  = '0;
                n_frame_len = '0;
                n_sum       = '0;
                n_chk_high  = '0;
                n_confirm   = '0;
                n_hdr_fault = 1'b0;
                n_id_fault  = 1'b0;
            end else begin
                n_byte_pos = r_byte_pos + 16'd1;
                if (w_is_chk_high) begin
                    n_chk_high = w_b;
                end else begin
                    n_sum = w_sum_add;
                    if (r_byte_pos == '0) begin
                        n_confirm = w_b;
                    end else begin
                        o_res_valid       = 1'b1;
                        o_res.kind        = KIND_PARAM;
                        o_res.param_byte  = w_b;
                        o_res.param_index = r_byte_pos - 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body   <= 1'b0;
            r_byte_pos  <= '0;
            r_frame_len <= '0;
            r_sum       <= '0;
            r_chk_high  <= '0;
            r_confirm   <= '0;
            r_hdr_fault <= 1'b0;
            r_id_fault  <= 1'b0;
        end else if (i_fire) begin
            r_in_body   <= n_in_body;
            r_byte_pos  <= n_byte_pos;
            r_frame_len <= n_frame_len;
            r_sum       <= n_sum;
            r_chk_high  <= n_chk_high;
            r_confirm   <= n_confirm;
            r_hdr_fault <= n_hdr_fault;
            r_id_fault  <= n_id_fault;
        end
    end

endmodule : scrd_parser

`default_nettype wire

/* src/scrd_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scrd_out_reg: result register
// Holds one result word for the receiver; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module scrd_out_reg
    import scrd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire logic      i_res_valid,
    input  wire t_out_word i_res,
    input  wire logic      i_stall,
    output logic           o_busy,
    output logic           o_valid,
    output t_out_word      o_word
);

    logic      r_valid;
    t_out_word r_word;

    // busy while a word sits here and the receiver is not taking it
    assign o_busy  = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_busy) begin
            r_valid <= i_fire && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_busy && i_fire) begin
            r_word <= i_res;
        end
    end

endmodule : scrd_out_reg

`default_nettype wire

/* sim/deframer_result_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// deframer_result_checker: result predictor and comparator for the deframer
// Watches both word channels and the register port, works out the words the
// deframer must give for each accepted input word and compares them in order.
// ----------------------------------------------------------------------------
module deframer_result_checker
    import scrd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire t_in_word    i_in_data,
    input  wire logic        i_in_stall,
    input  wire logic        i_out_valid,
    input  wire t_out_word   i_out_data,
    input  wire logic        i_out_stall,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output int               o_outstanding,
    output int               o_faults
);

    // register copies
    logic [7:0]  want_id;
    logic [15:0] len_limit;

    // framing state
    logic        in_body;
    logic [15:0] position;
    logic [15:0] frame_len;
    logic [15:0] run_sum;
    logic [7:0]  sum_hi;
    logic [7:0]  confirm;
    logic        hdr_bad;
    logic        id_bad;

    t_out_word   awaited_words [$];
    int          fault_total = 0;

    task automatic drop_frame();
        in_body   = 1'b0;
        position  = '0;
        frame_len = '0;
        run_sum   = '0;
        sum_hi    = '0;
        confirm   = '0;
        hdr_bad   = 1'b0;
        id_bad    = 1'b0;
    endtask

    task automatic deframe_word(input t_in_word w);
        t_out_word   res;
        logic [2:0]  st;
        logic [15:0] sum_rx;
        logic        has_res;
        res     = '0;
        has_res = 1'b0;
        if (w.req_type == REQ_RESTART) begin
            drop_frame();
        end else if (!in_body) begin
            if (position == POS_SYNC0 && w.rx_byte != HDR_BYTE0) hdr_bad = 1'b1;
            if (position == POS_SYNC1 && w.rx_byte != HDR_BYTE1) hdr_bad = 1'b1;
            if (position == POS_ID) begin
                if (w.rx_byte != want_id) id_bad = 1'b1;
                run_sum = {8'h00, w.rx_byte};
            end
            if (position == POS_LEN_HI) begin
                frame_len = {w.rx_byte, 8'h00};
                run_sum   = run_sum + {8'h00, w.rx_byte};
            end
            if (position == POS_HDR_END) begin
                frame_len = frame_len | {8'h00, w.rx_byte};
                run_sum   = run_sum + {8'h00, w.rx_byte};
                // judged in order: sync bytes, identifier, length range
                st = ST_OK;
                if (hdr_bad)
                    st = ST_BAD_HEADER;
                else if (id_bad)
                    st = ST_BAD_ID;
                else if (frame_len < MIN_LENGTH || frame_len > len_limit)
                    st = ST_BAD_LENGTH;
                if (st != ST_OK) begin
                    drop_frame();
                    res.kind       = KIND_RESULT;
                    res.status     = st;
                    res.frame_done = 1'b1;
                    has_res        = 1'b1;
                end else begin
                    in_body  = 1'b1;
                    position = '0;
                end
            end else begin
                position = position + 16'd1;
            end
        end else begin
            if (position == frame_len - 16'd1) begin
                sum_rx         = {sum_hi, w.rx_byte};
                res.kind       = KIND_RESULT;
                res.frame_done = 1'b1;
                if (sum_rx == run_sum) begin
                    res.status       = ST_OK;
                    res.confirm_code = confirm;
                    res.param_count  = frame_len - MIN_LENGTH;
                end else begin
                    res.status = ST_BAD_SUM;
                end
                has_res = 1'b1;
                drop_frame();
            end else if (position == frame_len - 16'd2) begin
                sum_hi   = w.rx_byte;
                position = position + 16'd1;
            end else begin
                run_sum = run_sum + {8'h00, w.rx_byte};
                if (position == 16'd0) begin
                    confirm = w.rx_byte;
                end else begin
                    res.kind        = KIND_PARAM;
                    res.param_byte  = w.rx_byte;
                    res.param_index = position - 16'd1;
                    has_res         = 1'b1;
                end
                position = position + 16'd1;
            end
        end
        if (has_res) awaited_words.push_back(res);
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fault_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            want_id   = RESET_PACKET_ID;
            len_limit = RESET_MAX_LENGTH;
            drop_frame();
            awaited_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDX_PACKET_ID:  want_id   = i_cfg_data[7:0];
                    CFG_IDX_MAX_LENGTH: len_limit = i_cfg_data;
                    default: ;
                endcase
            end
            // output first: a word taken now belongs to an earlier input
            if (i_out_valid && !i_out_stall) begin
                if (awaited_words.size() == 0) begin
                    $error("unexpected output word %h", i_out_data);
                    fault_total++;
                end else begin
                    want = awaited_words.pop_front();
                    compare_field("kind", want.kind, i_out_data.kind);
                    compare_field("param_byte", want.param_byte, i_out_data.param_byte);
                    compare_field("param_index", want.param_index, i_out_data.param_index);
                    compare_field("status", want.status, i_out_data.status);
                    compare_field("confirm_code", want.confirm_code,
                                  i_out_data.confirm_code);
                    compare_field("param_count", want.param_count, i_out_data.param_count);
                    compare_field("frame_done", want.frame_done, i_out_data.frame_done);
                end
            end
            if (i_in_valid && !i_in_stall) deframe_word(i_in_data);
        end
        o_outstanding <= awaited_words.size();
        o_faults      <= fault_total;
    end

endmodule : deframer_result_checker

`default_nettype wire

/* sim/sum_checked_response_deframer_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sum_checked_response_deframer_test: stimulus and verdict for the deframer
// Feeds directed and random response frames through five register settings,
// with random gaps on both channels; the checker beside the block predicts
// and compares every output word.
// ----------------------------------------------------------------------------
module sum_checked_response_deframer_test;
    import scrd_pkg::*;

    localparam int IDLE_LIMIT = 2000;   // cycles with no word moving on either side
    localparam int BODY_CAP   = 600;    // longest body actually sent after a header

    typedef enum int {
        FAULT_NONE,
        FAULT_SYNC0,
        FAULT_SYNC1,
        FAULT_SUM
    } frame_fault_e;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_word    i_in_data   = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_idx   = CFG_IDX_PACKET_ID;
    logic [15:0] i_cfg_data  = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    t_out_word   o_out_data;

    int          outstanding;
    int          faults;

    // our own view of the registers, to shape frames
    logic [7:0]  cur_id  = RESET_PACKET_ID;
    logic [15:0] cur_max = RESET_MAX_LENGTH;

    bit          in_gaps  = 1'b1;  // sender idles now and then
    bit          out_gaps = 1'b1;  // receiver stalls now and then
    int          words_sent = 0;
    int          idle_cycles = 0;

    sum_checked_response_deframer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    deframer_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .i_in_stall    (o_in_stall),
        .i_out_valid   (o_out_valid),
        .i_out_data    (o_out_data),
        .i_out_stall   (i_out_stall),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_outstanding (outstanding),
        .o_faults      (faults)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver: stalls at random about a tenth of the time unless switched off
    always @(posedge i_clk) begin
        i_out_stall <= out_gaps && ($urandom_range(0, 99) < 10);
    end

    // watchdog: a run that stops moving words is a failure
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // One word on the input channel. Valid stays high across back-to-back
    // words; a gap lowers it first. Returns just after the edge that took the word.
    task automatic send_word(input logic req, input logic [7:0] value);
        t_in_word w;
        w.req_type = req;
        w.rx_byte  = value;
        if (in_gaps && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_restart();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));   // ignored, but keep the bits moving
        send_word(REQ_RESTART, junk);
    endtask

    function automatic logic [7:0] pick_byte(input int fill);
        logic [7:0] v;
        if (fill < 0)
            v = 8'($urandom_range(0, 255));
        else
            v = fill[7:0];
        return v;
    endfunction

    // Builds one frame: header, and a body with its sum for no fault or a bad sum
    // when len is MIN_LENGTH..BODY_CAP. cut > 0 sends at most cut bytes, then a restart.
    task automatic send_frame(input logic [7:0] id, input logic [15:0] len,
                              input frame_fault_e fault, input int cut, input int fill);
        logic [7:0]  bytes [$];
        logic [15:0] sum;
        logic [7:0]  b;
        logic [7:0]  flip;
        int          k;
        bytes.push_back(HDR_BYTE0);
        bytes.push_back(HDR_BYTE1);
        for (k = 0; k < 4; k++) bytes.push_back(pick_byte(fill));
        bytes.push_back(id);
        bytes.push_back(len[15:8]);
        bytes.push_back(len[7:0]);
        sum  = {8'h00, id} + {8'h00, len[15:8]} + {8'h00, len[7:0]};
        flip = 8'($urandom_range(1, 255));
        if (fault == FAULT_SYNC0) bytes[0] = bytes[0] ^ flip;
        if (fault == FAULT_SYNC1) bytes[1] = bytes[1] ^ flip;
        if ((fault == FAULT_NONE || fault == FAULT_SUM) &&
            len >= MIN_LENGTH && int'(len) <= BODY_CAP) begin
            // confirm code and parameters, then the big-endian sum
            for (k = 0; k < int'(len) - 2; k++) begin
                b   = pick_byte(fill);
                sum = sum + {8'h00, b};
                bytes.push_back(b);
            end
            bytes.push_back(sum[15:8]);
            bytes.push_back(sum[7:0]);
            if (fault == FAULT_SUM) begin
                k        = $urandom_range(9, bytes.size() - 1);
                bytes[k] = bytes[k] ^ flip;
            end
        end
        if (cut > 0 && cut < bytes.size()) begin
            while (bytes.size() > cut) void'(bytes.pop_back());
        end
        for (k = 0; k < bytes.size(); k++) send_word(REQ_BYTE, bytes[k]);
        if (cut > 0) send_restart();
    endtask

    // Mostly well-formed frames under the current settings; the rest are
    // broken headers, bad sums, truncated frames and plain noise.
    task automatic random_frame();
        int          r;
        int          top_len;
        int          n;
        int          k;
        logic [15:0] len;
        logic [7:0]  flip;
        logic [7:0]  b;
        r    = $urandom_range(0, 99);
        flip = 8'($urandom_range(1, 255));
        if (cur_max >= MIN_LENGTH) begin
            top_len = (cur_max < 24) ? int'(cur_max) : 24;
            len     = 16'($urandom_range(int'(MIN_LENGTH), top_len));
            if ($urandom_range(0, 99) < 5 && cur_max <= 200) len = cur_max;
        end else begin
            len = 16'($urandom_range(0, 8));
        end
        if (r < 65) begin
            send_frame(cur_id, len, FAULT_NONE, 0, -1);
        end else if (r < 72) begin
            send_frame(cur_id, len, FAULT_SUM, 0, -1);
        end else if (r < 76) begin
            send_frame(cur_id, len, FAULT_SYNC0, 0, -1);
        end else if (r < 80) begin
            send_frame(cur_id, len, FAULT_SYNC1, 0, -1);
        end else if (r < 85) begin
            send_frame(cur_id ^ flip, len, FAULT_NONE, 0, -1);
        end else if (r < 90) begin
            // length out of range, short or long side
            if (cur_max == 16'hFFFF || $urandom_range(0, 1) == 0)
                len = 16'($urandom_range(0, 2));
            else if ($urandom_range(0, 3) == 0)
                len = 16'hFFFF;
            else
                len = cur_max + 16'd1;
            send_frame(cur_id, len, FAULT_NONE, 0, -1);
        end else if (r < 95) begin
            send_frame(cur_id, len, FAULT_NONE, $urandom_range(1, 9 + int'(len) - 1), -1);
        end else begin
            n = $urandom_range(1, 12);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_restart();
                end else begin
                    b = 8'($urandom_range(0, 255));
                    send_word(REQ_BYTE, b);
                end
            end
            if ($urandom_range(0, 99) < 80) send_restart();
        end
    endtask

    task automatic random_until(input int total);
        while (words_sent < total) random_frame();
    endtask

    // sender holds off until every predicted word has come out, so the block
    // is idle before registers change
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] id, input logic [15:0] max_len);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_PACKET_ID;
        i_cfg_data <= {8'h00, id};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDX_MAX_LENGTH;
        i_cfg_data <= max_len;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_id  = id;
        cur_max = max_len;
    endtask

    initial begin
        int         k;
        logic [7:0] b;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings (id 0x07, max 32)
        send_frame(cur_id, MIN_LENGTH, FAULT_NONE, 0, 255);      // shortest, all ones
        send_frame(cur_id, 16'd5, FAULT_NONE, 0, 0);             // all zero content
        send_frame(cur_id, cur_max, FAULT_NONE, 0, -1);          // longest accepted
        send_frame(cur_id, 16'd4, FAULT_SYNC0, 0, -1);
        send_frame(cur_id, 16'd4, FAULT_SYNC1, 0, -1);
        send_frame(cur_id ^ 8'h80, 16'd4, FAULT_NONE, 0, -1);    // wrong identifier
        send_frame(cur_id, 16'd2, FAULT_NONE, 0, -1);            // too short
        send_frame(cur_id, cur_max + 16'd1, FAULT_NONE, 0, -1);  // too long
        send_frame(cur_id, 16'd0, FAULT_NONE, 0, -1);
        send_frame(cur_id, 16'd6, FAULT_SUM, 0, -1);
        send_frame(cur_id, 16'd6, FAULT_NONE, 12, -1);           // restart mid body
        send_frame(cur_id, 16'd6, FAULT_NONE, 4, -1);            // restart mid header
        random_until(250);

        // smallest accepted limit: only three-byte bodies pass
        settle();
        set_config(8'h00, MIN_LENGTH);
        random_until(450);

        // widest settings, with no gaps on either side for a long stretch
        settle();
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        set_config(8'hFF, 16'hFFFF);
        send_frame(cur_id, 16'd300, FAULT_NONE, 0, -1);
        // largest length: header accepted, then dropped partway
        send_frame(cur_id, 16'hFFFF, FAULT_NONE, 0, -1);
        for (k = 0; k < 20; k++) begin
            b = 8'($urandom_range(0, 255));
            send_word(REQ_BYTE, b);
        end
        send_restart();
        random_until(1050);

        // limit below the minimum: every header is turned down
        settle();
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
        set_config(8'h5A, 16'd2);
        random_until(1150);
        send_restart();

        // random settings for the rest
        settle();
        set_config(8'($urandom_range(0, 255)), 16'($urandom_range(3, 48)));
        random_until(1400);

        settle();
        repeat (8) @(posedge i_clk);
        if (faults == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule : sum_checked_response_deframer_test

`default_nettype wire
